// ----- rtl/core/blca_pkg.sv -----
// Shared types and constants for the binary-lifting lowest common ancestor unit.
// Holds the node reference entry, request kinds and sequencer states.
// No dependencies.
package blca_pkg;

    // Node index and height widths are fixed by the request format
    localparam int NODE_W    = 10;
    localparam int DEPTH_W   = 10;
    localparam int HEIGHT_W  = 10;
    localparam int MAX_NODES = 1 << NODE_W;

    // Ancestor entry or result: a node index plus a "none" mark
    typedef struct packed {
        logic              none;
        logic [NODE_W-1:0] node;
    } node_ref_t;

    localparam node_ref_t REF_NONE = '{none: 1'b1, node: '0};

    // Request kinds; code 3 is unused and dropped
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LCA    = 2'd1,
        REQ_KTH    = 2'd2
    } req_kind_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_DEPTH,
        ST_INS_WR,
        ST_INS_RD,
        ST_LCA_DEPTH,
        ST_CLIMB,
        ST_CLIMB_WAIT,
        ST_DESC,
        ST_FINAL,
        ST_RESP
    } seq_state_t;

endpackage

// ----- rtl/core/blca_req_if.sv -----
// Request channel of the lowest common ancestor unit: valid/ready plus payload.
// Depends on blca_pkg.
interface blca_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     req_type;
    logic [blca_pkg::NODE_W-1:0]    node_a;
    logic [blca_pkg::NODE_W-1:0]    node_b;
    logic                           is_root;
    logic [blca_pkg::HEIGHT_W-1:0]  lift_height;

    modport source (output valid, req_type, node_a, node_b, is_root, lift_height,
                    input ready);
    modport sink   (input valid, req_type, node_a, node_b, is_root, lift_height,
                    output ready);
endinterface

// ----- rtl/core/blca_rsp_if.sv -----
// Result channel of the lowest common ancestor unit: valid/ready plus payload.
// Depends on blca_pkg.
interface blca_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [blca_pkg::NODE_W-1:0]  result_node;
    logic                         result_none;

    modport source (output valid, result_node, result_none, input ready);
    modport sink   (input valid, result_node, result_none, output ready);
endinterface

// ----- rtl/core/blca_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Read during write at the same address returns the old contents.
// No dependencies.
module blca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ----- rtl/core/blca_seq.sv -----
// Request sequencer: runs inserts, k-th ancestor climbs and common ancestor
// searches as read-modify-write steps on the depth and ancestor memories.
// Depends on blca_pkg and blca_req_if.
module blca_seq #(
    parameter int LEVELS = 11
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    blca_req_if.sink                                    req,
    // depth memory
    output logic                                        dep_we,
    output logic [blca_pkg::NODE_W-1:0]                 dep_waddr,
    output logic [blca_pkg::DEPTH_W-1:0]                dep_wdata,
    output logic [blca_pkg::NODE_W-1:0]                 dep_raddr0,
    output logic [blca_pkg::NODE_W-1:0]                 dep_raddr1,
    input  logic [blca_pkg::DEPTH_W-1:0]                dep_rdata0,
    input  logic [blca_pkg::DEPTH_W-1:0]                dep_rdata1,
    // ancestor memory, addressed by {node, level}
    output logic                                        anc_we,
    output logic [blca_pkg::NODE_W+$clog2(LEVELS)-1:0]  anc_waddr,
    output blca_pkg::node_ref_t                         anc_wdata,
    output logic [blca_pkg::NODE_W+$clog2(LEVELS)-1:0]  anc_raddr0,
    output logic [blca_pkg::NODE_W+$clog2(LEVELS)-1:0]  anc_raddr1,
    input  blca_pkg::node_ref_t                         anc_rdata0,
    input  blca_pkg::node_ref_t                         anc_rdata1,
    // result handoff
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output blca_pkg::node_ref_t                         res_data
);
    import blca_pkg::*;

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int CL_MAX = (LEVELS > HEIGHT_W) ? LEVELS : HEIGHT_W;
    localparam int CL_W   = $clog2(CL_MAX + 1);
    localparam logic [CL_W-1:0]  LVL_TOP = CL_W'(LEVELS - 1);
    localparam logic [CL_W-1:0]  LVL_LIM = CL_W'(LEVELS);
    localparam logic [LVL_W-1:0] LVL_TOP_A = LVL_W'(LEVELS - 1);

    seq_state_t            state_reg, state_next;
    logic [NODE_W-1:0]     n_reg, n_next;
    node_ref_t             x_reg, x_next;
    logic [NODE_W-1:0]     y_reg, y_next;
    logic [HEIGHT_W-1:0]   h_reg, h_next;
    logic [CL_W-1:0]       lvl_reg, lvl_next;
    logic                  lca_reg, lca_next;
    logic                  fwd_reg, fwd_next;
    node_ref_t             res_reg, res_next;

    req_kind_t             kind;
    logic                  climb_done;
    logic                  desc_step;
    logic [NODE_W-1:0]     x_desc;
    logic [NODE_W-1:0]     y_desc;
    logic [LVL_W-1:0]      lvl_a;
    logic [LVL_W-1:0]      lvl_dn_a;

    // Shared decode
    assign kind       = req_kind_t'(req.req_type);
    assign climb_done = (h_reg == '0) || x_reg.none;
    assign lvl_a      = lvl_reg[LVL_W-1:0];
    assign lvl_dn_a   = (lvl_reg == '0) ? '0 : lvl_a - 1'b1;

    // Descent step: move both nodes up only when the entries differ and both exist
    assign desc_step = (anc_rdata0 != anc_rdata1) && !anc_rdata0.none && !anc_rdata1.none;
    assign x_desc    = desc_step ? anc_rdata0.node : x_reg.node;
    assign y_desc    = desc_step ? anc_rdata1.node : y_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (kind)
                        REQ_INSERT: state_next = req.is_root ? ST_INS_WR : ST_INS_DEPTH;
                        REQ_LCA:    state_next = ST_LCA_DEPTH;
                        REQ_KTH:    state_next = ST_CLIMB;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS_DEPTH:  state_next = ST_INS_WR;
            ST_INS_WR:
            begin
                priority if (lvl_reg == LVL_TOP) state_next = ST_IDLE;
                else if (x_reg.none)             state_next = ST_INS_WR;
                else                             state_next = ST_INS_RD;
            end
            ST_INS_RD:     state_next = ST_INS_WR;
            ST_LCA_DEPTH:  state_next = ST_CLIMB;
            ST_CLIMB:
            begin
                if (climb_done)
                begin
                    if (!lca_reg || x_reg.none || (x_reg.node == y_reg))
                        state_next = ST_RESP;
                    else
                        state_next = ST_DESC;
                end
                else if (h_reg[0] && (lvl_reg < LVL_LIM))
                begin
                    state_next = ST_CLIMB_WAIT;
                end
            end
            ST_CLIMB_WAIT: state_next = ST_CLIMB;
            ST_DESC:       state_next = (lvl_reg == '0) ? ST_FINAL : ST_DESC;
            ST_FINAL:      state_next = ST_RESP;
            ST_RESP:       state_next = res_ready ? ST_IDLE : ST_RESP;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Working register updates
    always_comb
    begin
        n_next   = n_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        h_next   = h_reg;
        lvl_next = lvl_reg;
        lca_next = lca_reg;
        fwd_next = fwd_reg;
        res_next = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                n_next   = req.node_a;
                y_next   = req.node_b;
                h_next   = req.lift_height;
                lvl_next = '0;
                lca_next = (kind == REQ_LCA);
                if (kind == REQ_INSERT)
                    x_next = req.is_root ? REF_NONE : node_ref_t'{none: 1'b0, node: req.node_b};
                else
                    x_next = '{none: 1'b0, node: req.node_a};
            end
            ST_INS_WR:
            begin
                if (lvl_reg != LVL_TOP)
                    lvl_next = lvl_reg + 1'b1;
                // entry being written is the one read next: bypass it
                fwd_next = (x_reg.node == n_reg);
            end
            ST_INS_RD:
            begin
                x_next = fwd_reg ? x_reg : anc_rdata0;
            end
            ST_LCA_DEPTH:
            begin
                // climb the deeper node; ties keep the first node
                if (dep_rdata0 < dep_rdata1)
                begin
                    x_next = '{none: 1'b0, node: y_reg};
                    y_next = x_reg.node;
                    h_next = dep_rdata1 - dep_rdata0;
                end
                else
                begin
                    h_next = dep_rdata0 - dep_rdata1;
                end
            end
            ST_CLIMB:
            begin
                if (climb_done)
                begin
                    res_next = x_reg;
                    lvl_next = LVL_TOP;
                end
                else
                begin
                    h_next   = h_reg >> 1;
                    lvl_next = lvl_reg + 1'b1;
                    if (h_reg[0] && (lvl_reg >= LVL_LIM))
                        x_next = REF_NONE;
                end
            end
            ST_CLIMB_WAIT:
            begin
                x_next = anc_rdata0;
            end
            ST_DESC:
            begin
                x_next = '{none: 1'b0, node: x_desc};
                y_next = y_desc;
                if (lvl_reg != '0)
                    lvl_next = lvl_reg - 1'b1;
            end
            ST_FINAL:
            begin
                res_next = anc_rdata0;
            end
            default:
            begin
            end
        endcase
    end

    // Memory ports, handshakes
    always_comb
    begin
        req.ready  = 1'b0;
        res_valid  = 1'b0;
        dep_we     = 1'b0;
        dep_waddr  = n_reg;
        dep_wdata  = '0;
        dep_raddr0 = req.node_a;
        dep_raddr1 = req.node_b;
        anc_we     = 1'b0;
        anc_waddr  = {n_reg, lvl_a};
        anc_wdata  = x_reg;
        anc_raddr0 = {x_reg.node, lvl_a};
        anc_raddr1 = {y_reg, lvl_a};
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (kind == REQ_INSERT)
                    dep_raddr0 = req.node_b;
                // a root gets depth 0 right away
                if (req.valid && (kind == REQ_INSERT) && req.is_root)
                begin
                    dep_we    = 1'b1;
                    dep_waddr = req.node_a;
                end
            end
            ST_INS_DEPTH:
            begin
                dep_we    = 1'b1;
                dep_wdata = (&dep_rdata0) ? dep_rdata0 : dep_rdata0 + 1'b1;
            end
            ST_INS_WR:
            begin
                anc_we = 1'b1;
            end
            ST_CLIMB:
            begin
                if (climb_done)
                begin
                    anc_raddr0 = {x_reg.node, LVL_TOP_A};
                    anc_raddr1 = {y_reg, LVL_TOP_A};
                end
            end
            ST_DESC:
            begin
                anc_raddr0 = {x_desc, lvl_dn_a};
                anc_raddr1 = {y_desc, lvl_dn_a};
            end
            ST_RESP:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res_data = res_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        h_reg   <= h_next;
        lvl_reg <= lvl_next;
        lca_reg <= lca_next;
        fwd_reg <= fwd_next;
        res_reg <= res_next;
    end

endmodule

// ----- rtl/core/blca_out_reg.sv -----
// Output register of the result channel: holds one finished result so the
// sequencer can take the next request while it waits.
// Depends on blca_pkg and blca_rsp_if.
module blca_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  blca_pkg::node_ref_t in_data,
    blca_rsp_if.source          rsp
);
    import blca_pkg::*;

    logic              valid_reg, valid_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic              none_reg, none_next;
    logic              load;

    assign in_ready = !valid_reg || rsp.ready;
    assign load     = in_valid && in_ready;

    // Next values; a missing node reads as zero
    always_comb
    begin
        valid_next = valid_reg;
        node_next  = node_reg;
        none_next  = none_reg;
        if (load)
        begin
            valid_next = 1'b1;
            node_next  = in_data.none ? '0 : in_data.node;
            none_next  = in_data.none;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        none_reg <= none_next;
    end

    assign rsp.valid       = valid_reg;
    assign rsp.result_node = node_reg;
    assign rsp.result_none = none_reg;

endmodule

// ----- rtl/core/binary_lifting_lca_unit.sv -----
// Binary-lifting lowest common ancestor unit: top level.
// Depends on blca_pkg, blca_req_if, blca_rsp_if, blca_ram, blca_seq, blca_out_reg.
//
//  channel  dir  payload                                          result
//  req      in   req_type, node_a, node_b, is_root, lift_height   insert: none
//  rsp      out  result_node, result_none                         one per query
//
// From the accept: an insert writes one ancestor entry per level, a child first
// its depth, with a read between writes while the ancestor exists. k-th ancestor:
// a step per bit of lift_height up to its top set bit, with a read wait per set bit,
// then a closing step and the handoff. Common ancestor: accept, a depth step,
// the climb on the depth difference, then a descent step per level and a final read
// unless the nodes already meet or the climb left the tree, then the handoff. Reset
// clears only the sequencer state and output valid; the handoff stalls while the output is full.
module binary_lifting_lca_unit #(
    parameter int LEVELS = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    blca_req_if.sink    req,
    blca_rsp_if.source  rsp
);
    import blca_pkg::*;

    localparam int LVL_W     = $clog2(LEVELS);
    localparam int ANC_DEPTH = MAX_NODES * (2 ** LVL_W);
    localparam int ANC_AW    = NODE_W + LVL_W;

    logic                dep_we;
    logic [NODE_W-1:0]   dep_waddr;
    logic [DEPTH_W-1:0]  dep_wdata;
    logic [NODE_W-1:0]   dep_raddr0;
    logic [NODE_W-1:0]   dep_raddr1;
    logic [DEPTH_W-1:0]  dep_rdata0;
    logic [DEPTH_W-1:0]  dep_rdata1;

    logic                anc_we;
    logic [ANC_AW-1:0]   anc_waddr;
    node_ref_t           anc_wdata;
    logic [ANC_AW-1:0]   anc_raddr0;
    logic [ANC_AW-1:0]   anc_raddr1;
    node_ref_t           anc_rdata0;
    node_ref_t           anc_rdata1;

    logic                res_valid;
    logic                res_ready;
    node_ref_t           res_data;

    // Depth of every node
    blca_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_NODES)
    ) u_depth_ram (
        .clk    (clk),
        .we     (dep_we),
        .waddr  (dep_waddr),
        .wdata  (dep_wdata),
        .raddr0 (dep_raddr0),
        .raddr1 (dep_raddr1),
        .rdata0 (dep_rdata0),
        .rdata1 (dep_rdata1)
    );

    // 2^i-th ancestor of every node
    blca_ram #(
        .WIDTH ($bits(node_ref_t)),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .clk    (clk),
        .we     (anc_we),
        .waddr  (anc_waddr),
        .wdata  (anc_wdata),
        .raddr0 (anc_raddr0),
        .raddr1 (anc_raddr1),
        .rdata0 (anc_rdata0),
        .rdata1 (anc_rdata1)
    );

    blca_seq #(
        .LEVELS (LEVELS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .dep_we     (dep_we),
        .dep_waddr  (dep_waddr),
        .dep_wdata  (dep_wdata),
        .dep_raddr0 (dep_raddr0),
        .dep_raddr1 (dep_raddr1),
        .dep_rdata0 (dep_rdata0),
        .dep_rdata1 (dep_rdata1),
        .anc_we     (anc_we),
        .anc_waddr  (anc_waddr),
        .anc_wdata  (anc_wdata),
        .anc_raddr0 (anc_raddr0),
        .anc_raddr1 (anc_raddr1),
        .anc_rdata0 (anc_rdata0),
        .anc_rdata1 (anc_rdata1),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    blca_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_data  (res_data),
        .rsp      (rsp)
    );

    // Ancestor table is written only while an insert is in progress
    a_anc_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        anc_we |-> !req.ready)
        else $error("ancestor write while sequencer idle");

    // Every depth write is followed by the first ancestor level write
    a_depth_then_anc: assert property (@(posedge clk) disable iff (!rst_n)
        dep_we |=> anc_we)
        else $error("depth write not followed by ancestor write");

    // A missing node reads as zero on the result channel
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.result_none) |-> (rsp.result_node == '0))
        else $error("none result with nonzero node");

    // A result handed over while busy never lands while the request side is taking work
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !req.ready)
        else $error("result handoff while sequencer idle");

endmodule

// ----- dv/blca_answer_checker.sv -----
// Checker for the binary-lifting lowest common ancestor unit: watches both channels,
// keeps its own depth and ancestor tables, predicts each query answer and compares.
// Depends on blca_pkg, blca_req_if and blca_rsp_if.
module blca_answer_checker #(
    parameter int LEVELS = 11
) (
    input  logic clk,
    input  logic rst_n,
    blca_req_if  req,
    blca_rsp_if  rsp,
    output int   err_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import blca_pkg::*;

    localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;

    // Shadow copies of the two tables
    logic [DEPTH_W-1:0] depth_tab [MAX_NODES];
    node_ref_t          up_tab    [MAX_NODES][LEVELS];

    // Answers owed by the block, oldest first
    node_ref_t answers_due [$];

    int n_mismatch = 0;
    int n_due      = 0;

    assign err_count = n_mismatch;
    assign pending   = n_due;

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        n_mismatch++;
    endtask

    // Climb by the set bits of the height, one table level per bit
    function automatic node_ref_t climb_up(input node_ref_t start,
                                           input logic [HEIGHT_W-1:0] height);
        node_ref_t           x;
        logic [HEIGHT_W-1:0] h;
        int                  lvl;
        x   = start;
        h   = height;
        lvl = 0;
        while (h != '0 && !x.none)
        begin
            if (h[0])
            begin
                if (lvl >= LEVELS)
                    x = REF_NONE;
                else
                    x = up_tab[x.node][lvl];
            end
            h = h >> 1;
            lvl++;
        end
        return x;
    endfunction

    // Level the depths, then descend from the top level
    function automatic node_ref_t common_up(input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] x, y, t;
        node_ref_t         lifted, ax, ay;
        int                lvl;
        x = a;
        y = b;
        if (depth_tab[x] < depth_tab[y])
        begin
            t = x;
            x = y;
            y = t;
        end
        lifted = climb_up('{none: 1'b0, node: x}, depth_tab[x] - depth_tab[y]);
        if (lifted.none)
            return REF_NONE;
        x = lifted.node;
        if (x == y)
            return lifted;
        for (lvl = LEVELS - 1; lvl >= 0; lvl--)
        begin
            ax = up_tab[x][lvl];
            ay = up_tab[y][lvl];
            // one side none: level counts as equal, no step
            if (ax != ay && !ax.none && !ay.none)
            begin
                x = ax.node;
                y = ay.node;
            end
        end
        return up_tab[x][0];
    endfunction

    // Insert: depth from the parent (saturating), ancestors level by level; a root gets depth 0 and no ancestors
    function automatic void add_node(input logic [NODE_W-1:0] n,
                                     input logic [NODE_W-1:0] p,
                                     input logic              root);
        node_ref_t prev;
        int        lvl;
        if (root)
        begin
            depth_tab[n] = '0;
            for (lvl = 0; lvl < LEVELS; lvl++)
                up_tab[n][lvl] = REF_NONE;
        end
        else
        begin
            depth_tab[n] = (depth_tab[p] >= DEPTH_SAT) ? DEPTH_SAT : depth_tab[p] + 1'b1;
            up_tab[n][0] = '{none: 1'b0, node: p};
            for (lvl = 1; lvl < LEVELS; lvl++)
            begin
                prev = up_tab[n][lvl-1];
                up_tab[n][lvl] = prev.none ? REF_NONE : up_tab[prev.node][lvl-1];
            end
        end
    endfunction

    // Results are matched first: one accepted in the same cycle as a new request
    // always belongs to an earlier one
    always @(posedge clk)
    begin : watch_channels
        node_ref_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    report_mismatch($sformatf("result node %0d none %0b with no query waiting",
                                              rsp.result_node, rsp.result_none));
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.result_node !== want.node || rsp.result_none !== want.none)
                        report_mismatch($sformatf(
                            "result node %0d none %0b, expected node %0d none %0b",
                            rsp.result_node, rsp.result_none, want.node, want.none));
                end
            end
            if (req.valid && req.ready)
            begin
                case (req.req_type)
                    REQ_INSERT: add_node(req.node_a, req.node_b, req.is_root);
                    REQ_LCA:    answers_due.push_back(common_up(req.node_a, req.node_b));
                    REQ_KTH:    answers_due.push_back(climb_up('{none: 1'b0, node: req.node_a},
                                                               req.lift_height));
                    default:    ;
                endcase
            end
        end
        n_due = answers_due.size();
    end

endmodule

// ----- dv/tb_binary_lifting_lca_unit.sv -----
// Top of the testbench for binary_lifting_lca_unit: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Checking lives in blca_answer_checker.
// Depends on blca_pkg, blca_req_if, blca_rsp_if, blca_answer_checker and the block.
module tb_binary_lifting_lca_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import blca_pkg::*;

    localparam int         LEVELS         = 11;
    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         PHASE_ITEMS    = 110;
    localparam int         RECENT_DEPTH   = 32;
    localparam int         LONG_HOLD      = 300;
    localparam int         TAIL_CYCLES    = 64;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;

    bit idle_send       = 1'b1;
    bit idle_recv       = 1'b1;
    int hold_cycles_req = 0;
    int quiet_cycles    = 0;
    int n_err;
    int n_due;

    logic [NODE_W-1:0] recent_nodes [$];

    blca_req_if req_ch ();
    blca_rsp_if rsp_ch ();

    binary_lifting_lca_unit #(
        .LEVELS(LEVELS)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    blca_answer_checker #(
        .LEVELS(LEVELS)
    ) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .err_count(n_err),
        .pending  (n_due)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: cycles in a row with nothing accepted on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random hold-off before each result, plus one long stall on demand
    initial
    begin : result_sink
        int gap_left;
        gap_left     = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles_req > 0)
            begin
                gap_left        = hold_cycles_req;
                hold_cycles_req = 0;
            end
            if (gap_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                gap_left = idle_recv ? $urandom_range(0, 7) : 0;
        end
    end

    function automatic logic [NODE_W-1:0] rnd_node();
        return NODE_W'($urandom);
    endfunction

    function automatic logic [NODE_W-1:0] pick_recent();
        return recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
    endfunction

    // One request: optional gap, then hold valid until accepted. Entered and left
    // at a falling edge; valid stays high so back-to-back requests need no toggle.
    task automatic send_req(input logic [1:0]          kind,
                            input logic [NODE_W-1:0]   a,
                            input logic [NODE_W-1:0]   b,
                            input logic                root,
                            input logic [HEIGHT_W-1:0] h);
        int gap;
        gap = idle_send ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.node_a      <= a;
        req_ch.node_b      <= b;
        req_ch.is_root     <= root;
        req_ch.lift_height <= h;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every owed answer has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (n_due != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [NODE_W-1:0]   na, nb;
        logic [HEIGHT_W-1:0] ht;
        logic                root;
        int                  pick, n_sent, ph, i;

        req_ch.valid       = 1'b0;
        req_ch.req_type    = '0;
        req_ch.node_a      = '0;
        req_ch.node_b      = '0;
        req_ch.is_root     = 1'b0;
        req_ch.lift_height = '0;
        rst_n              = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: two small trees, extremes of nodes and heights
        send_req(REQ_INSERT, 10'd1023, 10'd1023, 1'b1, 10'd1023);   // root, parent ignored
        send_req(REQ_INSERT, 10'd0,    10'd1023, 1'b0, 10'd0);
        send_req(REQ_INSERT, 10'd5,    10'd0,    1'b0, rnd_node());
        send_req(REQ_INSERT, 10'd7,    10'd0,    1'b1, rnd_node()); // second tree
        send_req(REQ_INSERT, 10'd8,    10'd7,    1'b0, rnd_node());
        send_req(REQ_INSERT, 10'd9,    10'd5,    1'b0, rnd_node());
        send_req(REQ_INSERT, 10'd10,   10'd9,    1'b0, rnd_node());
        send_req(REQ_INSERT, 10'd11,   10'd0,    1'b0, rnd_node());
        send_req(REQ_KTH, 10'd5,    rnd_node(), 1'b1, 10'd0);
        send_req(REQ_KTH, 10'd5,    rnd_node(), 1'b0, 10'd1);
        send_req(REQ_KTH, 10'd5,    rnd_node(), 1'b1, 10'd2);
        send_req(REQ_KTH, 10'd5,    rnd_node(), 1'b0, 10'd3);       // above the root
        send_req(REQ_KTH, 10'd5,    10'd1023,   1'b1, 10'd1023);
        send_req(REQ_KTH, 10'd1023, rnd_node(), 1'b0, 10'd1);       // root has no parent
        send_req(REQ_LCA, 10'd5,    10'd5,      1'b1, 10'd1023);
        send_req(REQ_LCA, 10'd5,    10'd0,      1'b0, rnd_node());
        send_req(REQ_LCA, 10'd0,    10'd5,      1'b1, rnd_node());
        send_req(REQ_LCA, 10'd10,   10'd11,     1'b0, rnd_node());
        send_req(REQ_LCA, 10'd5,    10'd8,      1'b0, rnd_node());  // different trees
        send_req(REQ_LCA, 10'd1023, 10'd8,      1'b1, rnd_node());
        send_req(REQ_UNUSED, 10'd1023, 10'd1023, 1'b1, 10'd1023);   // dropped, no answer
        send_req(REQ_UNUSED, rnd_node(), rnd_node(), 1'b0, rnd_node());
        wait_drained();

        // Full-length chain 0..1023, then re-hang 0 below 1023: depth saturates and
        // the descent meets a level where only one side is none
        idle_send = 1'b0;
        idle_recv = 1'b0;
        send_req(REQ_INSERT, 10'd0, rnd_node(), 1'b1, rnd_node());
        for (i = 1; i < MAX_NODES; i++)
            send_req(REQ_INSERT, NODE_W'(i), NODE_W'(i - 1), 1'b0, rnd_node());
        idle_send = 1'b1;
        idle_recv = 1'b1;
        send_req(REQ_KTH, 10'd1023, rnd_node(), 1'b0, 10'd1023);
        send_req(REQ_KTH, 10'd1023, rnd_node(), 1'b1, 10'd1000);
        send_req(REQ_KTH, 10'd700,  rnd_node(), 1'b0, 10'd512);
        send_req(REQ_LCA, 10'd1023, 10'd512,    1'b1, rnd_node());
        send_req(REQ_LCA, 10'd1000, 10'd1023,   1'b0, rnd_node());
        send_req(REQ_INSERT, 10'd0, 10'd1023,   1'b0, rnd_node());
        send_req(REQ_INSERT, 10'd1, 10'd0,      1'b0, rnd_node());
        send_req(REQ_KTH, 10'd0,    rnd_node(), 1'b1, 10'd1023);
        send_req(REQ_LCA, 10'd0,    10'd1023,   1'b0, rnd_node());
        send_req(REQ_LCA, 10'd1,    10'd1023,   1'b1, rnd_node());
        send_req(REQ_LCA, 10'd0,    10'd0,      1'b0, rnd_node());
        wait_drained();
        recent_nodes.push_back(10'd1023);
        recent_nodes.push_back(10'd0);
        recent_nodes.push_back(10'd1);

        // Random phases with different idling; the first starts with a long stall
        // of the result side so the block backs up into the request channel
        for (ph = 0; ph < 4; ph++)
        begin
            idle_send = (ph == 0) || (ph == 2);
            idle_recv = (ph == 0) || (ph == 3);
            if (ph == 0)
                hold_cycles_req = LONG_HOLD;
            n_sent = 0;
            while (n_sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                na   = rnd_node();
                nb   = rnd_node();
                if (pick < 40)
                begin
                    // insert, mostly below the newest node so trees grow deep
                    root = ($urandom_range(0, 15) == 0);
                    pick = $urandom_range(0, 9);
                    if (!root && pick < 6)
                        nb = recent_nodes[$];
                    else if (!root && pick < 9)
                        nb = pick_recent();
                    send_req(REQ_INSERT, na, nb, root, rnd_node());
                    recent_nodes.push_back(na);
                    if (recent_nodes.size() > RECENT_DEPTH)
                        void'(recent_nodes.pop_front());
                    n_sent++;
                end
                else if (pick < 70)
                begin
                    if ($urandom_range(0, 4) != 0)
                    begin
                        na = pick_recent();
                        nb = pick_recent();
                    end
                    send_req(REQ_LCA, na, nb, 1'($urandom), rnd_node());
                    n_sent++;
                end
                else if (pick < 95)
                begin
                    if ($urandom_range(0, 4) != 0)
                        na = pick_recent();
                    ht = $urandom_range(0, 1) ? HEIGHT_W'($urandom_range(0, 15)) : rnd_node();
                    send_req(REQ_KTH, na, nb, 1'($urandom), ht);
                    n_sent++;
                end
                else
                begin
                    send_req(REQ_UNUSED, na, nb, 1'($urandom), rnd_node());
                end
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (n_err == 0 && n_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
